// ----- design/skia_pkg.sv -----
// ============================================================================
// skia_pkg: shared types and constants of the keyed interval accumulator
// Holds the payload structs, outcome codes and table dimensions.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
package skia_pkg;

	localparam int NumCpus      = 8;
	localparam int TableEntries = 4096;
	localparam int MaxFrames    = 4;
	localparam int CpuW   = (NumCpus > 1) ? $clog2(NumCpus) : 1;
	localparam int SlotW  = $clog2(TableEntries);
	localparam int CountW = SlotW + 1;
	localparam int FrameW = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;

	localparam logic [2:0] OUT_FIRST   = 3'd0;
	localparam logic [2:0] OUT_EMPTY   = 3'd1;
	localparam logic [2:0] OUT_ACCUM   = 3'd2;
	localparam logic [2:0] OUT_INSERT  = 3'd3;
	localparam logic [2:0] OUT_DROPPED = 3'd4;

	typedef struct packed {
		logic [2:0]  cpu_index;
		logic [63:0] timestamp;
		logic [2:0]  stack_depth;
		logic [63:0] frame_zero;
		logic [63:0] frame_one;
		logic [63:0] frame_two;
		logic [63:0] frame_three;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  outcome;
		logic [63:0] stack_hash;
		logic [63:0] interval;
		logic [63:0] record_total;
		logic [12:0] records_in_use;
		logic [63:0] dropped_count;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the input item
		logic mix_step;  // one hash round over the current frame
		logic finish;    // final avalanche of the hash
		logic rd_slot;   // issue a table read at the scan slot
		logic next_slot; // advance the scan slot
		logic hit_upd;   // write the accumulated total
		logic insert;    // write a new record
		logic drop;      // count a dropped event
		logic [2:0] outcome;
		logic emit;      // load the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic first;       // no prior event on this cpu
		logic empty;       // stack depth zero
		logic mix_done;    // all frames mixed
		logic scan_end;    // scan slot reached the fill count
		logic key_match;   // read record matches the key
		logic full;        // table full
		logic out_busy;    // output register still holds a result
	} sts_t;

endpackage
`default_nettype wire

// ----- design/skia_datapath.sv -----
// ============================================================================
// skia_datapath: hash unit, per-cpu start times and the record table
// Runs one hash round per cycle while mixing, and issues table reads, under controller command.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module skia_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire skia_pkg::in_item_t  in_item,
	input  wire skia_pkg::cmd_t      cmd,
	output skia_pkg::sts_t           sts,
	output skia_pkg::out_item_t      out_item,
	output logic                     out_valid,
	input  wire logic                out_ready
);
	localparam int KeyW = 64 + 3 + 64 * skia_pkg::MaxFrames;

	logic [63:0] cpu_start_q [skia_pkg::NumCpus];
	logic [skia_pkg::CpuW-1:0] cpu_q;
	logic [63:0] now_q, interval_q, hash_q, total_q, dropped_q;
	logic [2:0]  depth_q;
	logic [63:0] frames_q [skia_pkg::MaxFrames];
	logic [skia_pkg::FrameW:0] mix_idx_q;
	logic [skia_pkg::CountW-1:0] used_q, scan_q;
	logic [skia_pkg::SlotW-1:0] rd_slot_q;
	logic first_q;

	// Record memory: key and total, read data registered.
	logic [KeyW-1:0] key_mem [skia_pkg::TableEntries];
	logic [63:0]     tot_mem [skia_pkg::TableEntries];
	logic [KeyW-1:0] key_rd_q;
	logic [63:0]     tot_rd_q;
	logic [KeyW-1:0] key_now;

	logic [2:0]  depth_sat;
	logic [skia_pkg::CpuW-1:0] cpu_in;
	logic [63:0] in_fr [4];
	logic [63:0] h1, h2, h3, f1, f2;
	logic [63:0] new_total;

	always_comb begin
		in_fr[0] = in_item.frame_zero;
		in_fr[1] = in_item.frame_one;
		in_fr[2] = in_item.frame_two;
		in_fr[3] = in_item.frame_three;
		depth_sat = (in_item.stack_depth > 3'(skia_pkg::MaxFrames))
			? 3'(skia_pkg::MaxFrames) : in_item.stack_depth;
		cpu_in = skia_pkg::CpuW'(32'(in_item.cpu_index) % skia_pkg::NumCpus);
	end

	// One mix round and the final avalanche.
	always_comb begin
		h1 = hash_q + frames_q[mix_idx_q[skia_pkg::FrameW-1:0]];
		h2 = h1 + (h1 << 10);
		h3 = h2 ^ (h2 >> 6);
		f1 = hash_q + (hash_q << 3);
		f1 = f1 ^ (f1 >> 11);
		f2 = f1 + (f1 << 15);
	end

	always_comb begin
		key_now = '0;
		key_now[63:0]  = hash_q;
		key_now[66:64] = depth_q;
		for (int i = 0; i < skia_pkg::MaxFrames; i++) begin
			key_now[67 + 64*i +: 64] = frames_q[i];
		end
		new_total = tot_rd_q + interval_q;
	end

	always_comb begin
		sts.first     = first_q;
		sts.empty     = (depth_q == 3'd0);
		sts.mix_done  = (mix_idx_q == (skia_pkg::FrameW+1)'(depth_q));
		sts.scan_end  = (scan_q == used_q);
		sts.key_match = (key_rd_q == key_now);
		sts.full      = (used_q == skia_pkg::CountW'(skia_pkg::TableEntries));
		sts.out_busy  = out_valid;
	end

	// Item capture and hash state.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cpu_q   <= cpu_in;
			now_q   <= in_item.timestamp;
			depth_q <= depth_sat;
			for (int i = 0; i < skia_pkg::MaxFrames; i++) begin
				frames_q[i] <= (i < 4 && 3'(i) < depth_sat) ? in_fr[i] : 64'd0;
			end
			interval_q <= in_item.timestamp - cpu_start_q[cpu_in];
			first_q    <= (cpu_start_q[cpu_in] == 64'd0);
			hash_q     <= 64'd0;
			mix_idx_q  <= '0;
		end else if (cmd.mix_step) begin
			hash_q    <= h3;
			mix_idx_q <= mix_idx_q + 1'b1;
		end else if (cmd.finish) begin
			hash_q <= f2;
		end
		if (cmd.hit_upd) begin
			total_q <= new_total;
		end else if (cmd.insert) begin
			total_q <= interval_q;
		end
	end

	// Per-cpu start times.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < skia_pkg::NumCpus; i++) cpu_start_q[i] <= 64'd0;
		end else if (cmd.emit) begin
			cpu_start_q[cpu_q] <= now_q;
		end
	end

	// Scan pointer, fill count and drop counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			scan_q    <= '0;
			dropped_q <= 64'd0;
			rd_slot_q <= '0;
		end else begin
			if (cmd.load) scan_q <= '0;
			else if (cmd.next_slot) scan_q <= scan_q + 1'b1;
			if (cmd.rd_slot) rd_slot_q <= scan_q[skia_pkg::SlotW-1:0];
			if (cmd.insert) used_q <= used_q + 1'b1;
			if (cmd.drop) dropped_q <= dropped_q + 64'd1;
		end
	end

	// Record table ports.
	always_ff @(posedge clk) begin
		if (cmd.rd_slot) begin
			key_rd_q <= key_mem[scan_q[skia_pkg::SlotW-1:0]];
			tot_rd_q <= tot_mem[scan_q[skia_pkg::SlotW-1:0]];
		end
		if (cmd.insert) begin
			key_mem[used_q[skia_pkg::SlotW-1:0]] <= key_now;
			tot_mem[used_q[skia_pkg::SlotW-1:0]] <= interval_q;
		end else if (cmd.hit_upd) begin
			tot_mem[rd_slot_q] <= new_total;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_item.outcome      <= cmd.outcome;
			out_item.stack_hash   <= (cmd.outcome == skia_pkg::OUT_FIRST
				|| cmd.outcome == skia_pkg::OUT_EMPTY) ? 64'd0 : hash_q;
			out_item.interval     <= (cmd.outcome == skia_pkg::OUT_FIRST)
				? 64'd0 : interval_q;
			out_item.record_total <= (cmd.outcome == skia_pkg::OUT_ACCUM
				|| cmd.outcome == skia_pkg::OUT_INSERT) ? total_q : 64'd0;
			out_item.records_in_use <= 13'(used_q);
			out_item.dropped_count  <= dropped_q;
		end
	end

endmodule
`default_nettype wire

// ----- design/skia_ctrl.sv -----
// ============================================================================
// skia_ctrl: sequencer of the keyed interval accumulator
// Steps events through check, hashing, table scan and update, insert or drop.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module skia_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire skia_pkg::sts_t sts,
	output skia_pkg::cmd_t      cmd
);
	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_CHECK  = 9'b000000010,
		ST_MIX    = 9'b000000100,
		ST_FINISH = 9'b000001000,
		ST_SCAN   = 9'b000010000,
		ST_WAIT   = 9'b000100000,
		ST_CMP    = 9'b001000000,
		ST_UPD    = 9'b010000000,
		ST_EMIT   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic [2:0] outc_q, outc_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		outc_d  = outc_q;
		cmd     = '0;
		cmd.outcome = outc_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.first) begin
					outc_d = skia_pkg::OUT_FIRST; state_d = ST_EMIT;
				end else if (sts.empty) begin
					outc_d = skia_pkg::OUT_EMPTY; state_d = ST_EMIT;
				end else begin
					state_d = ST_MIX;
				end
			end
			ST_MIX: begin
				if (sts.mix_done) state_d = ST_FINISH;
				else cmd.mix_step = 1'b1;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_SCAN;
			end
			// Read the next used slot, or decide insert or drop at the end.
			ST_SCAN: begin
				if (sts.scan_end) begin
					if (sts.full) begin
						outc_d = skia_pkg::OUT_DROPPED; cmd.drop = 1'b1;
					end else begin
						outc_d = skia_pkg::OUT_INSERT; cmd.insert = 1'b1;
					end
					state_d = ST_EMIT;
				end else begin
					cmd.rd_slot   = 1'b1;
					cmd.next_slot = 1'b1;
					state_d       = ST_WAIT;
				end
			end
			ST_WAIT: state_d = ST_CMP;
			ST_CMP: begin
				if (sts.key_match) state_d = ST_UPD;
				else state_d = ST_SCAN;
			end
			ST_UPD: begin
				cmd.hit_upd = 1'b1;
				outc_d      = skia_pkg::OUT_ACCUM;
				state_d     = ST_EMIT;
			end
			ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			outc_q  <= skia_pkg::OUT_FIRST;
		end else begin
			state_q <= state_d;
			outc_q  <= outc_d;
		end
	end

endmodule
`default_nettype wire

// ----- design/stack_keyed_interval_accumulator_top.sv -----
// A first or empty-stack event goes from the check straight to the output register; any other
// event is hashed frame by frame, then scans the used records with a read, a wait and a compare
// per slot, ending in an update on a hit, an insert or a drop.
// Throughput: one event at a time; the next is taken in the cycle after the result is loaded.
// Reset clears start times, fill count and drop counter; no clearing pass.
// ============================================================================
// stack_keyed_interval_accumulator_top: top level of the accumulator
// Joins the sequencer and the datapath.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module stack_keyed_interval_accumulator_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire skia_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output skia_pkg::out_item_t      out_data
);
	skia_pkg::cmd_t cmd;
	skia_pkg::sts_t sts;

	skia_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sts(sts), .cmd(cmd)
	);

	skia_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .cmd(cmd), .sts(sts),
		.out_item(out_data), .out_valid(out_valid), .out_ready(out_ready)
	);

endmodule
`default_nettype wire
